// ===== hw/rtl/emst_pkg.sv =====
package emst_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  localparam int IDX_W  = 5;
  localparam int LEN_W  = 25;
  localparam int COST_W = 31;

  localparam int FROM_LSB = 0;
  localparam int TO_LSB   = FROM_LSB + IDX_W;
  localparam int LEN_LSB  = TO_LSB + IDX_W;
  localparam int COST_LSB = LEN_LSB + LEN_W;

  localparam int USER_EDGE = 0;
  localparam int USER_OVF  = 1;

  localparam int FRAC_SHIFT = 18;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [LEN_W-1:0]  LEN_MIN_EDGE = LEN_W'(256);

endpackage

// ===== hw/rtl/euclidean_min_spanning_tree_unit.sv =====
// Euclidean minimum spanning tree over up to MAX_POINTS points. Points stream in on the
// slave side; each point is checked against the stored set one entry per cycle, and
// duplicates are dropped. The point with tlast starts the tree: a Prim pass per tree edge
// runs over all points through one shared squarer and one shared key comparator, then the
// tree edges are sent in ascending key order, each found by a scan of the edge list
// followed by an iterative square root. Results carry index pair, Q17.8 length and the
// saturating running cost; a set of one point gives one result with no edge. The next
// point is taken once the last result has been loaded for sending.
module euclidean_min_spanning_tree_unit #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [emst_pkg::IN_DATA_W-1:0]   s_tdata,   // x_coord, y_coord
  input  logic                             s_tlast,   // last_point
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [emst_pkg::OUT_DATA_W-1:0]  m_tdata,   // from_index, to_index, edge_length, running_cost
  output logic [emst_pkg::OUT_USER_W-1:0]  m_tuser,   // edge_valid, overflow
  output logic                             m_tlast    // last_edge
);
  import emst_pkg::*;

  localparam int MP  = MAX_POINTS;
  localparam int CB  = COORD_BITS;
  localparam int IW  = $clog2(MP);
  localparam int CW  = $clog2(MP + 1);
  localparam int D2W = 2 * CB + 1;
  localparam int NW  = ((D2W + FRAC_SHIFT + 1) / 2) * 2;
  localparam int RW  = NW / 2;
  localparam int SW  = $clog2(RW + 1);

  typedef struct packed {
    logic [D2W-1:0]       d2;
    logic signed [CB-1:0] lox;
    logic signed [CB-1:0] loy;
    logic signed [CB-1:0] hix;
    logic signed [CB-1:0] hiy;
  } key_t;

  typedef enum logic [3:0] {
    IDLE, DUP, START, ONE, P_SQX, P_SQY, P_UPD, P_MIN, P_END, E_SCAN, SQRT, E_OUT
  } state_t;

  function automatic logic key_before(key_t a, key_t b);
    logic r;
    priority if (a.d2 != b.d2) r = a.d2 < b.d2;
    else if (a.lox != b.lox)  r = a.lox < b.lox;
    else if (a.loy != b.loy)  r = a.loy < b.loy;
    else if (a.hix != b.hix)  r = a.hix < b.hix;
    else                      r = a.hiy < b.hiy;
    return r;
  endfunction

  state_t state;

  logic signed [CB-1:0] px [MP];
  logic signed [CB-1:0] py [MP];
  logic [CW-1:0] count;
  logic          ovf;
  logic [COST_W-1:0] cost;

  logic signed [CB-1:0] ix, iy;
  logic                 ilast, dupf;
  logic [CW-1:0]        scan;

  logic [MP-1:0]        in_tree, has_best;
  logic [D2W-1:0]       best_d2 [MP];
  logic signed [CB-1:0] best_ox [MP];
  logic signed [CB-1:0] best_oy [MP];
  logic [IW-1:0]        best_src [MP];

  logic signed [CB-1:0] cur_x, cur_y;
  logic [IW-1:0]        cur_idx;
  logic [2*CB-1:0]      sqx;
  key_t                 new_key;

  key_t                 min_key;
  logic                 min_valid;
  logic [IW-1:0]        min_idx, min_lo, min_hi;
  logic signed [CB-1:0] min_sx, min_sy;

  key_t          te_key [MP-1];
  logic [IW-1:0] te_lo  [MP-1];
  logic [IW-1:0] te_hi  [MP-1];
  logic [MP-2:0] te_done;
  logic [CW-1:0] tcount, ecount;

  logic [NW-1:0]   rad;
  logic [RW+1:0]   rem;
  logic [RW-1:0]   root;
  logic [SW-1:0]   sq_cnt;

  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_USER_W-1:0] out_user;
  logic                  out_last;

  logic [IW-1:0]        si;
  logic signed [CB:0]   diff;
  logic [CB-1:0]        sq_op;
  logic [2*CB-1:0]      prod;
  key_t                 best_key, cmp_a, cmp_b;
  logic                 cmp_lt, out_free, out_load, is_last_edge;
  logic [RW+1:0]        rem_sh, trial;
  logic [RW:0]          root_inc;
  logic [RW-1:0]        root_rnd;
  logic [LEN_W-1:0]     len;
  logic [COST_W:0]      cost_sum;
  logic [COST_W-1:0]    cost_next;

  assign si       = scan[IW-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == ONE || state == E_OUT);
  assign s_tready = (state == IDLE);
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

  always_comb begin
    if (state == P_SQX) diff = {cur_x[CB-1], cur_x} - {px[si][CB-1], px[si]};
    else                diff = {cur_y[CB-1], cur_y} - {py[si][CB-1], py[si]};
    sq_op = diff[CB] ? CB'(-diff) : diff[CB-1:0];
    prod  = sq_op * sq_op;
  end

  always_comb begin
    best_key.d2 = best_d2[si];
    if (best_src[si] < si) begin
      best_key.lox = best_ox[si];
      best_key.loy = best_oy[si];
      best_key.hix = px[si];
      best_key.hiy = py[si];
    end else begin
      best_key.lox = px[si];
      best_key.loy = py[si];
      best_key.hix = best_ox[si];
      best_key.hiy = best_oy[si];
    end
    if (state == P_UPD) begin
      cmp_a = new_key;
      cmp_b = best_key;
    end else if (state == P_MIN) begin
      cmp_a = best_key;
      cmp_b = min_key;
    end else begin
      cmp_a = te_key[si];
      cmp_b = min_key;
    end
    cmp_lt = key_before(cmp_a, cmp_b);
  end

  always_comb begin
    rem_sh   = {rem[RW-1:0], rad[NW-1:NW-2]};
    trial    = {root, 2'b01};
    root_inc = {1'b0, root} + 1'b1;
    root_rnd = root_inc[RW:1];
    if ((root_rnd >> LEN_W) != 0) len = LEN_MAX;
    else                          len = LEN_W'(root_rnd);
    cost_sum  = {1'b0, cost} + (COST_W + 1)'(len);
    cost_next = (cost_sum > {1'b0, COST_MAX}) ? COST_MAX : cost_sum[COST_W-1:0];
    is_last_edge = (CW'(ecount + 1'b1) == tcount);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      cost     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            ix    <= CB'($signed(s_tdata[15:0]));
            iy    <= CB'($signed(s_tdata[31:16]));
            ilast <= s_tlast;
            dupf  <= 1'b0;
            scan  <= '0;
            state <= DUP;
          end
        end
        DUP: begin
          if (scan == count) begin
            if (!dupf) begin
              if (count < CW'(MP)) begin
                px[count[IW-1:0]] <= ix;
                py[count[IW-1:0]] <= iy;
                count <= count + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
            end
            scan  <= '0;
            state <= ilast ? START : IDLE;
          end else begin
            if (px[si] == ix && py[si] == iy) dupf <= 1'b1;
            scan <= scan + 1'b1;
          end
        end
        START: begin
          if (count <= CW'(1)) begin
            state <= ONE;
          end else begin
            in_tree    <= MP'(1);
            has_best   <= '0;
            cur_x      <= px[si];
            cur_y      <= py[si];
            cur_idx    <= '0;
            tcount     <= '0;
            min_valid  <= 1'b0;
            state      <= P_SQX;
          end
        end
        ONE: begin
          if (out_free) begin
            out_data <= '0;
            out_user <= {ovf, 1'b0};
            out_last <= 1'b1;
            count    <= '0;
            ovf      <= 1'b0;
            cost     <= '0;
            state    <= IDLE;
          end
        end
        P_SQX: begin
          if (scan == count) begin
            state <= P_END;
          end else if (in_tree[si]) begin
            scan <= scan + 1'b1;
          end else begin
            sqx   <= prod;
            state <= P_SQY;
          end
        end
        P_SQY: begin
          new_key.d2 <= {1'b0, sqx} + {1'b0, prod};
          if (cur_idx < si) begin
            new_key.lox <= cur_x;
            new_key.loy <= cur_y;
            new_key.hix <= px[si];
            new_key.hiy <= py[si];
          end else begin
            new_key.lox <= px[si];
            new_key.loy <= py[si];
            new_key.hix <= cur_x;
            new_key.hiy <= cur_y;
          end
          state <= P_UPD;
        end
        P_UPD: begin
          if (!has_best[si] || cmp_lt) begin
            best_d2[si]  <= new_key.d2;
            best_ox[si]  <= cur_x;
            best_oy[si]  <= cur_y;
            best_src[si] <= cur_idx;
            has_best[si] <= 1'b1;
          end
          state <= P_MIN;
        end
        P_MIN: begin
          if (!min_valid || cmp_lt) begin
            min_key   <= best_key;
            min_valid <= 1'b1;
            min_idx   <= si;
            min_sx    <= px[si];
            min_sy    <= py[si];
            if (best_src[si] < si) begin
              min_lo <= best_src[si];
              min_hi <= si;
            end else begin
              min_lo <= si;
              min_hi <= best_src[si];
            end
          end
          scan  <= scan + 1'b1;
          state <= P_SQX;
        end
        P_END: begin
          te_key[tcount[IW-1:0]] <= min_key;
          te_lo[tcount[IW-1:0]]  <= min_lo;
          te_hi[tcount[IW-1:0]]  <= min_hi;
          in_tree[min_idx]       <= 1'b1;
          cur_x     <= min_sx;
          cur_y     <= min_sy;
          cur_idx   <= min_idx;
          tcount    <= tcount + 1'b1;
          min_valid <= 1'b0;
          scan      <= '0;
          if (CW'(tcount + 1'b1) == CW'(count - 1'b1)) begin
            te_done <= '0;
            ecount  <= '0;
            state   <= E_SCAN;
          end else begin
            state <= P_SQX;
          end
        end
        E_SCAN: begin
          if (scan == tcount) begin
            rad    <= NW'({min_key.d2, FRAC_SHIFT'(0)});
            rem    <= '0;
            root   <= '0;
            sq_cnt <= SW'(RW);
            state  <= SQRT;
          end else begin
            if (!te_done[si] && (!min_valid || cmp_lt)) begin
              min_key   <= te_key[si];
              min_valid <= 1'b1;
              min_idx   <= si;
              min_lo    <= te_lo[si];
              min_hi    <= te_hi[si];
            end
            scan <= scan + 1'b1;
          end
        end
        SQRT: begin
          if (sq_cnt == '0) begin
            state <= E_OUT;
          end else begin
            if (rem_sh >= trial) begin
              rem  <= rem_sh - trial;
              root <= {root[RW-2:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              root <= {root[RW-2:0], 1'b0};
            end
            rad    <= {rad[NW-3:0], 2'b00};
            sq_cnt <= sq_cnt - 1'b1;
          end
        end
        E_OUT: begin
          if (out_free) begin
            out_data  <= OUT_DATA_W'({cost_next, len, IDX_W'(min_hi), IDX_W'(min_lo)});
            out_user  <= {ovf, 1'b1};
            out_last  <= is_last_edge;
            te_done[min_idx] <= 1'b1;
            ecount    <= ecount + 1'b1;
            min_valid <= 1'b0;
            scan      <= '0;
            if (is_last_edge) begin
              count <= '0;
              ovf   <= 1'b0;
              cost  <= '0;
              state <= IDLE;
            end else begin
              cost  <= cost_next;
              state <= E_SCAN;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/emst_checker.sv =====
module emst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [emst_pkg::IN_DATA_W-1:0]   s_tdata,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [emst_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [emst_pkg::OUT_USER_W-1:0]  m_tuser,
  input logic                             m_tlast
);
  import emst_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // a result without an edge is the lone-point result
  a_no_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_EDGE] |-> m_tlast && m_tdata == '0)
    else $error("empty result malformed");

  // distinct points give a length of at least one
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_EDGE] |-> m_tdata[LEN_LSB +: LEN_W] >= LEN_MIN_EDGE)
    else $error("edge length too short");

  // running cost covers the current edge
  a_cost: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_EDGE] |->
      m_tdata[COST_LSB +: COST_W] >= COST_W'(m_tdata[LEN_LSB +: LEN_W]))
    else $error("running cost below edge length");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind euclidean_min_spanning_tree_unit emst_checker u_emst_checker (.*);

// ===== sim/euclidean_min_spanning_tree_unit_tb.sv =====
`timescale 1ns / 1ps

module euclidean_min_spanning_tree_unit_tb;
  import emst_pkg::*;

  localparam int MAX_PTS = 32;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [IDX_W-1:0]  from_idx;
    logic [IDX_W-1:0]  to_idx;
    logic [LEN_W-1:0]  length;
    logic [COST_W-1:0] cost;
    logic              edge_valid;
    logic              overflow;
    logic              last_edge;
  } tree_edge_t;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] q8_length(longint unsigned d2);
    longint unsigned r;
    if (d2 >= (64'd1 << 34)) return LEN_MAX;
    r = (int_sqrt(d2 << FRAC_SHIFT) + 1) >> 1;
    if (r > longint'(LEN_MAX)) return LEN_MAX;
    return r[LEN_W-1:0];
  endfunction

  class mst_scoreboard;
    int px[MAX_PTS];
    int py[MAX_PTS];
    int count;
    bit ovf_seen;
    tree_edge_t pending_edges[$];
    int fails;
    int checked;

    function void clear_set();
      count = 0;
      ovf_seen = 0;
    endfunction

    function int pending();
      return pending_edges.size();
    endfunction

    function bit pair_before(int a1, int b1, longint unsigned d1,
                             int a2, int b2, longint unsigned d2);
      if (d1 != d2) return d1 < d2;
      if (px[a1] != px[a2]) return px[a1] < px[a2];
      if (py[a1] != py[a2]) return py[a1] < py[a2];
      if (px[b1] != px[b2]) return px[b1] < px[b2];
      return py[b1] < py[b2];
    endfunction

    function void note_point(int x, int y, bit last);
      bit dup;
      int ea[$];
      int eb[$];
      longint unsigned ed[$];
      int label[MAX_PTS];
      int ta, tb, j, la, lb, accepted;
      longint unsigned td, dx, dy, sum;
      logic [COST_W-1:0] acc;
      tree_edge_t e;
      dup = 0;
      for (int i = 0; i < count; i++)
        if (px[i] == x && py[i] == y) dup = 1;
      if (!dup) begin
        if (count < MAX_PTS) begin
          px[count] = x;
          py[count] = y;
          count++;
        end else begin
          ovf_seen = 1;
        end
      end
      if (!last) return;
      for (int i = 0; i + 1 < count; i++)
        for (int k = i + 1; k < count; k++) begin
          dx = (px[i] > px[k]) ? px[i] - px[k] : px[k] - px[i];
          dy = (py[i] > py[k]) ? py[i] - py[k] : py[k] - py[i];
          ea = {ea, i};
          eb = {eb, k};
          ed = {ed, dx * dx + dy * dy};
        end
      for (int i = 1; i < ea.size(); i++) begin
        ta = ea[i]; tb = eb[i]; td = ed[i];
        j = i;
        while (j > 0 && pair_before(ta, tb, td, ea[j-1], eb[j-1], ed[j-1])) begin
          ea[j] = ea[j-1]; eb[j] = eb[j-1]; ed[j] = ed[j-1];
          j--;
        end
        ea[j] = ta; eb[j] = tb; ed[j] = td;
      end
      for (int i = 0; i < count; i++) label[i] = i;
      acc = '0;
      if (count <= 1) begin
        e = '{from_idx: '0, to_idx: '0, length: '0, cost: '0, edge_valid: 1'b0,
              overflow: ovf_seen, last_edge: 1'b1};
        pending_edges = {pending_edges, e};
      end else begin
        accepted = 0;
        for (int k = 0; k < ea.size() && accepted + 1 < count; k++) begin
          la = label[ea[k]];
          lb = label[eb[k]];
          if (la == lb) continue;
          for (int i = 0; i < count; i++)
            if (label[i] == lb) label[i] = la;
          e.length = q8_length(ed[k]);
          sum = longint'(acc) + longint'(e.length);
          acc = (sum > longint'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
          accepted++;
          e.from_idx = IDX_W'(ea[k]);
          e.to_idx = IDX_W'(eb[k]);
          e.cost = acc;
          e.edge_valid = 1'b1;
          e.overflow = ovf_seen;
          e.last_edge = (accepted + 1 == count);
          pending_edges = {pending_edges, e};
        end
      end
      clear_set();
    endfunction

    function void check(tree_edge_t got);
      tree_edge_t want;
      checked++;
      if (pending_edges.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
        return;
      end
      want = pending_edges.pop_front();
      if (got.from_idx !== want.from_idx) begin
        $error("from_index: expected %0d, got %0d", want.from_idx, got.from_idx); fails++;
      end
      if (got.to_idx !== want.to_idx) begin
        $error("to_index: expected %0d, got %0d", want.to_idx, got.to_idx); fails++;
      end
      if (got.length !== want.length) begin
        $error("edge_length: expected %0d, got %0d", want.length, got.length); fails++;
      end
      if (got.cost !== want.cost) begin
        $error("running_cost: expected %0d, got %0d", want.cost, got.cost); fails++;
      end
      if (got.edge_valid !== want.edge_valid) begin
        $error("edge_valid: expected %0d, got %0d", want.edge_valid, got.edge_valid); fails++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow); fails++;
      end
      if (got.last_edge !== want.last_edge) begin
        $error("last_edge: expected %0d, got %0d", want.last_edge, got.last_edge); fails++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  mst_scoreboard sb;
  int cyc = 0;
  int hold_start;
  int points_sent;
  int sets_sent;
  int burst_left;
  bit no_gaps;
  tree_edge_t got;

  euclidean_min_spanning_tree_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** euclidean_min_spanning_tree_unit: FAILED **");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // receiver stall pattern, plus one long hold-off
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_start >= 0 && cyc - hold_start < HOLD_CYCLES)
        m_tready <= 0;
      else
        case ((cyc / 300) % 4)
          0: m_tready <= 1;
          1: m_tready <= $urandom_range(0, 1);
          2: m_tready <= ((cyc % 7) < 2);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.from_idx   = m_tdata[FROM_LSB +: IDX_W];
      got.to_idx     = m_tdata[TO_LSB +: IDX_W];
      got.length     = m_tdata[LEN_LSB +: LEN_W];
      got.cost       = m_tdata[COST_LSB +: COST_W];
      got.edge_valid = m_tuser[USER_EDGE];
      got.overflow   = m_tuser[USER_OVF];
      got.last_edge  = m_tlast;
      sb.check(got);
    end
  end

  task automatic send_point(int x, int y, bit last);
    if (!no_gaps && burst_left == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1;
    s_tdata  <= {16'(y), 16'(x)};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_point(x, y, last);
    points_sent++;
    if (last) sets_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_random_set(int n, bit narrow);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        x = $urandom_range(0, 6) - 3;
        y = $urandom_range(0, 6) - 3;
      end else begin
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_set();
    hold_start = -1;
    points_sent = 0;
    sets_sent = 0;
    burst_left = 0;
    no_gaps = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tlast = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single point at the corner
    send_point(-32768, -32768, 1);
    // longest possible edge
    send_point(-32768, -32768, 0);
    send_point(32767, 32767, 1);
    // duplicates and equal-length ties
    send_point(0, 0, 0);
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(0, 1, 0);
    send_point(1, 1, 1);
    // final point duplicate leaves a single point
    send_point(5, 5, 0);
    send_point(5, 5, 1);
    // mixed extremes
    send_point(32767, -32768, 0);
    send_point(-32768, 32767, 0);
    send_point(0, -1, 0);
    send_point(-1, 0, 1);

    s_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);

    // long receiver hold-off while points keep coming
    hold_start = cyc;
    no_gaps = 1;
    send_random_set(3, 0);
    send_random_set(4, 1);
    no_gaps = 0;

    // more points than the store holds
    for (int i = 0; i < 35; i++)
      send_point(i * 911 - 16000, $signed(16'($urandom)), i == 34);
    // full store
    send_random_set(32, 0);

    while (points_sent < 260) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        send_random_set($urandom_range(12, 24), $urandom_range(0, 1));
      else
        send_random_set($urandom_range(1, 8), $urandom_range(0, 2) == 0);
      if (sets_sent == 20) begin
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    s_tvalid <= 0;
    s_tlast <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("run covered %0d points in %0d sets, %0d tree results checked",
             points_sent, sets_sent, sb.checked);
    if (sb.fails == 0)
      $display("** euclidean_min_spanning_tree_unit: PASSED **");
    else
      $display("** euclidean_min_spanning_tree_unit: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/emst_pkg.sv
hw/rtl/euclidean_min_spanning_tree_unit.sv
hw/rtl/emst_checker.sv
sim/euclidean_min_spanning_tree_unit_tb.sv
